// ===== hw/rtl/bpoc_pkg.sv =====
// bpoc_pkg: sizes, marker values and the walk stack word for the odd cycle vertex counter
// used by the top level and its checker, depends on nothing
package bpoc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 4096;

   localparam int VTX_W  = $clog2(MAX_VERTICES);   // vertex index
   localparam int EIDX_W = $clog2(MAX_EDGES);      // edge store index
   localparam int ECNT_W = EIDX_W + 1;             // edge count, holds MAX_EDGES
   localparam int SLOT_W = EIDX_W + 2;             // list slot plus room for the end marker
   localparam int TIME_W = VTX_W + 1;              // discovery clock, holds MAX_VERTICES
   localparam int OUT_W  = 11;                     // result total width
   localparam int CFG_W  = 11;                     // vertex_count register width

   localparam logic [SLOT_W-1:0] LINK_END  = '1;
   localparam logic [VTX_W:0]    NO_PARENT = {1'b1, {VTX_W{1'b0}}};
   localparam logic [OUT_W-1:0]  TOTAL_LIMIT = '1;

   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef struct packed {
      logic [VTX_W-1:0]  vertex;
      logic [SLOT_W-1:0] cursor;
      logic              colour;
   } frame_type;

   localparam int FRAME_W = $bits(frame_type);

endpackage

// ===== hw/rtl/bpoc_ram.sv =====
// bpoc_ram: generic single write, single read ram with registered read data
// no package dependency
module bpoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wa,
   input  logic [WIDTH-1:0]         wd,
   input  logic [$clog2(DEPTH)-1:0] ra,
   output logic [WIDTH-1:0]         rq
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rq_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      rq_ff <= mem_ff[ra];
   end

   assign rq = rq_ff;

endmodule

// ===== hw/rtl/bridge_pruned_odd_cycle_vertex_count.sv =====
// bridge_pruned_odd_cycle_vertex_count: edge store, bridge search and two-coloring sequencer
// depends on bpoc_pkg and bpoc_ram
// sequence: an edge word is stored and busy stays low; a finish word clears every list and seen
//   mark, builds the lists, walks from each root one list slot at a time, opening or popping a
//   vertex as it goes, and scans the parent list on each bridge found before the coloring pass
// throughput: one word at a time, start is ignored while busy is high
// result: rsp_valid is high for exactly one cycle per finish word, the receiver cannot stall
// reset: synchronous, clears the edge count, drop flag and sequencer, vertex_count goes to 1
module bridge_pruned_odd_cycle_vertex_count
   import bpoc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // command side
   input  logic              start,
   output logic              busy,
   input  logic              req_kind,
   input  logic [VTX_W-1:0]  req_end_a,
   input  logic [VTX_W-1:0]  req_end_b,
   // result strobe
   output logic              rsp_valid,
   output logic [OUT_W-1:0]  rsp_odd_vertex_total,
   output logic              rsp_edges_dropped,
   // register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_vertex_count
);

   // sequencer codes
   localparam logic [4:0] S_IDLE = 5'd0,  S_CLR  = 5'd1,  S_B0 = 5'd2,  S_B1 = 5'd3;
   localparam logic [4:0] S_B2   = 5'd4,  S_B3   = 5'd5,  S_B4 = 5'd6,  S_R0 = 5'd7;
   localparam logic [4:0] S_R1   = 5'd8,  S_R2   = 5'd9,  S_W0 = 5'd10, S_W1 = 5'd11;
   localparam logic [4:0] S_W2   = 5'd12, S_W3   = 5'd13, S_P0 = 5'd14, S_P1 = 5'd15;
   localparam logic [4:0] S_P2   = 5'd16, S_M0   = 5'd17, S_M1 = 5'd18, S_M2 = 5'd19;
   localparam logic [4:0] S_CLR2 = 5'd20, S_C0   = 5'd21, S_C1 = 5'd22, S_C2 = 5'd23;
   localparam logic [4:0] S_K0   = 5'd24, S_K1   = 5'd25, S_K2 = 5'd26, S_K3 = 5'd27;
   localparam logic [4:0] S_K4   = 5'd28, S_DONE = 5'd29;

   // control registers
   logic [4:0]        state_ff, state_in;
   logic [CFG_W-1:0]  vcount_ff, vcount_in;
   logic [ECNT_W-1:0] etot_ff, etot_in;
   logic              ovf_ff, ovf_in;

   // walk registers
   logic [TIME_W-1:0] idx_ff, idx_in;     // clear sweep
   logic [ECNT_W-1:0] e_ff, e_in;         // list build edge
   logic [VTX_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [TIME_W-1:0] r_ff, r_in;         // walk root
   logic [TIME_W-1:0] tick_ff, tick_in;   // discovery clock
   logic [TIME_W-1:0] depth_ff, depth_in; // frames including the top
   logic [VTX_W-1:0]  tu_ff, tu_in;       // top frame vertex
   logic [SLOT_W-1:0] tcur_ff, tcur_in;   // top frame cursor
   logic [VTX_W:0]    tpar_ff, tpar_in;   // parent of the top vertex
   logic [TIME_W-1:0] tlow_ff, tlow_in;   // low link of the top vertex
   logic              tcol_ff, tcol_in;   // color of the top vertex
   logic [VTX_W-1:0]  v_ff, v_in;         // far end under test
   logic [VTX_W-1:0]  mu_ff, mu_in;       // child vertex of a bridge scan
   logic [TIME_W-1:0] ulow_ff, ulow_in;   // low link of the popped child
   logic [SLOT_W-1:0] ms_ff, ms_in;       // bridge scan cursor
   logic [OUT_W-1:0]  cnt_ff, cnt_in;     // component size
   logic              odd_ff, odd_in;
   logic [OUT_W-1:0]  total_ff, total_in;

   // ram ports
   logic                          edge_we;
   logic [EIDX_W-1:0]             edge_wa, edge_ra;
   logic [2*VTX_W-1:0]            edge_wd, edge_rq;
   logic                          head_we;
   logic [VTX_W-1:0]              head_wa, head_ra;
   logic [SLOT_W-1:0]             head_wd, head_rq;
   logic                          next_we;
   logic [EIDX_W:0]               next_wa, next_ra;
   logic [SLOT_W-1:0]             next_wd, next_rq;
   logic                          brg_we;
   logic [EIDX_W-1:0]             brg_wa, brg_ra;
   logic                          brg_wd, brg_rq;
   logic                          seen_we;
   logic [VTX_W-1:0]              seen_wa, seen_ra;
   logic                          seen_wd, seen_rq;
   logic                          par_we;
   logic [VTX_W-1:0]              par_wa, par_ra;
   logic [VTX_W:0]                par_wd, par_rq;
   logic                          disc_we;
   logic [VTX_W-1:0]              disc_wa, disc_ra;
   logic [TIME_W-1:0]             disc_wd, disc_rq;
   logic                          low_we;
   logic [VTX_W-1:0]              low_wa, low_ra;
   logic [TIME_W-1:0]             low_wd, low_rq;
   logic                          col_we;
   logic [VTX_W-1:0]              col_wa, col_ra;
   logic                          col_wd, col_rq;
   logic                          stk_we;
   logic [VTX_W-1:0]              stk_wa, stk_ra;
   frame_type                     stk_wd, stk_rq;

   // helpers
   logic [TIME_W-1:0] starts;
   logic [TIME_W-1:0] depth_m1, depth_m2, tick_p1;
   logic [VTX_W-1:0]  far_cur, far_ms;
   logic [SLOT_W-1:0] slot_even, slot_odd;
   logic [OUT_W:0]    total_sum;

   // walks start at vertices below vertex_count, capped at the store size
   assign starts = (vcount_ff > CFG_W'(MAX_VERTICES)) ? TIME_W'(MAX_VERTICES)
                                                       : TIME_W'(vcount_ff);
   assign depth_m1 = depth_ff - TIME_W'(1);
   assign depth_m2 = depth_ff - TIME_W'(2);
   assign tick_p1  = tick_ff + TIME_W'(1);
   // slot 2e is in the list of the first end, its far end is the second
   assign far_cur  = tcur_ff[0] ? edge_rq[2*VTX_W-1:VTX_W] : edge_rq[VTX_W-1:0];
   assign far_ms   = ms_ff[0]   ? edge_rq[2*VTX_W-1:VTX_W] : edge_rq[VTX_W-1:0];
   assign slot_even = {1'b0, e_ff[EIDX_W-1:0], 1'b0};
   assign slot_odd  = {1'b0, e_ff[EIDX_W-1:0], 1'b1};
   assign total_sum = {1'b0, total_ff} + {1'b0, cnt_ff};

   always_comb begin
      state_in  = state_ff;
      vcount_in = vcount_ff;
      etot_in   = etot_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      e_in      = e_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      r_in      = r_ff;
      tick_in   = tick_ff;
      depth_in  = depth_ff;
      tu_in     = tu_ff;
      tcur_in   = tcur_ff;
      tpar_in   = tpar_ff;
      tlow_in   = tlow_ff;
      tcol_in   = tcol_ff;
      v_in      = v_ff;
      mu_in     = mu_ff;
      ulow_in   = ulow_ff;
      ms_in     = ms_ff;
      cnt_in    = cnt_ff;
      odd_in    = odd_ff;
      total_in  = total_ff;

      edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
      head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
      brg_we  = 1'b0; brg_wa  = '0; brg_wd  = 1'b0; brg_ra = '0;
      seen_we = 1'b0; seen_wa = '0; seen_wd = 1'b0; seen_ra = '0;
      par_we  = 1'b0; par_wa  = '0; par_wd  = '0; par_ra  = '0;
      disc_we = 1'b0; disc_wa = '0; disc_wd = '0; disc_ra = '0;
      low_we  = 1'b0; low_wa  = '0; low_wd  = '0; low_ra  = '0;
      col_we  = 1'b0; col_wa  = '0; col_wd  = 1'b0; col_ra = '0;
      stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;

      if (csr_valid) begin
         vcount_in = csr_vertex_count;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_kind == KIND_EDGE) begin
                  // a full store drops the word and remembers it
                  if (etot_ff == ECNT_W'(MAX_EDGES)) begin
                     ovf_in = 1'b1;
                  end else begin
                     edge_we = 1'b1;
                     edge_wa = etot_ff[EIDX_W-1:0];
                     edge_wd = {req_end_a, req_end_b};
                     etot_in = etot_ff + ECNT_W'(1);
                  end
               end else begin
                  idx_in   = '0;
                  state_in = S_CLR;
               end
            end
         end
         // empty every list and the seen marks
         S_CLR: begin
            head_we = 1'b1; head_wa = idx_ff[VTX_W-1:0]; head_wd = LINK_END;
            seen_we = 1'b1; seen_wa = idx_ff[VTX_W-1:0]; seen_wd = 1'b0;
            idx_in  = idx_ff + TIME_W'(1);
            if (idx_ff == TIME_W'(MAX_VERTICES - 1)) begin
               e_in     = '0;
               state_in = S_B0;
            end
         end
         // list build, newest edge first in every list
         S_B0: begin
            if (e_ff == etot_ff) begin
               r_in     = '0;
               tick_in  = '0;
               state_in = S_R0;
            end else begin
               edge_ra  = e_ff[EIDX_W-1:0];
               state_in = S_B1;
            end
         end
         S_B1: begin
            a_in     = edge_rq[2*VTX_W-1:VTX_W];
            b_in     = edge_rq[VTX_W-1:0];
            head_ra  = edge_rq[2*VTX_W-1:VTX_W];
            state_in = S_B2;
         end
         S_B2: begin
            next_we = 1'b1; next_wa = slot_even[EIDX_W:0]; next_wd = head_rq;
            head_we = 1'b1; head_wa = a_ff; head_wd = slot_even;
            state_in = S_B3;
         end
         S_B3: begin
            head_ra  = b_ff;
            state_in = S_B4;
         end
         S_B4: begin
            next_we = 1'b1; next_wa = slot_odd[EIDX_W:0]; next_wd = head_rq;
            head_we = 1'b1; head_wa = b_ff; head_wd = slot_odd;
            brg_we  = 1'b1; brg_wa = e_ff[EIDX_W-1:0]; brg_wd = 1'b0;
            e_in     = e_ff + ECNT_W'(1);
            state_in = S_B0;
         end
         // bridge search roots
         S_R0: begin
            if (r_ff == starts) begin
               idx_in   = '0;
               state_in = S_CLR2;
            end else begin
               seen_ra  = r_ff[VTX_W-1:0];
               state_in = S_R1;
            end
         end
         S_R1: begin
            if (seen_rq) begin
               r_in     = r_ff + TIME_W'(1);
               state_in = S_R0;
            end else begin
               tick_in = tick_p1;
               seen_we = 1'b1; seen_wa = r_ff[VTX_W-1:0]; seen_wd = 1'b1;
               disc_we = 1'b1; disc_wa = r_ff[VTX_W-1:0]; disc_wd = tick_p1;
               low_we  = 1'b1; low_wa  = r_ff[VTX_W-1:0]; low_wd  = tick_p1;
               par_we  = 1'b1; par_wa  = r_ff[VTX_W-1:0]; par_wd  = NO_PARENT;
               head_ra = r_ff[VTX_W-1:0];
               tlow_in = tick_p1;
               state_in = S_R2;
            end
         end
         S_R2: begin
            tu_in    = r_ff[VTX_W-1:0];
            tcur_in  = head_rq;
            tpar_in  = NO_PARENT;
            depth_in = TIME_W'(1);
            state_in = S_W0;
         end
         // advance the top frame by one list slot
         S_W0: begin
            if (tcur_ff == LINK_END) begin
               state_in = S_P0;
            end else begin
               edge_ra  = tcur_ff[EIDX_W:1];
               next_ra  = tcur_ff[EIDX_W:0];
               state_in = S_W1;
            end
         end
         S_W1: begin
            v_in     = far_cur;
            tcur_in  = next_rq;
            seen_ra  = far_cur;
            disc_ra  = far_cur;
            state_in = S_W2;
         end
         S_W2: begin
            if (!seen_rq) begin
               // tree edge: push the current frame, the child becomes the top
               tick_in = tick_p1;
               seen_we = 1'b1; seen_wa = v_ff; seen_wd = 1'b1;
               disc_we = 1'b1; disc_wa = v_ff; disc_wd = tick_p1;
               low_we  = 1'b1; low_wa  = v_ff; low_wd  = tick_p1;
               par_we  = 1'b1; par_wa  = v_ff; par_wd  = {1'b0, tu_ff};
               stk_we  = 1'b1; stk_wa  = depth_m1[VTX_W-1:0];
               stk_wd  = '{vertex: tu_ff, cursor: tcur_ff, colour: 1'b0};
               head_ra = v_ff;
               tpar_in = {1'b0, tu_ff};
               tu_in   = v_ff;
               tlow_in = tick_p1;
               depth_in = depth_ff + TIME_W'(1);
               state_in = S_W3;
            end else begin
               // every edge back to the parent vertex is skipped
               if (({1'b0, v_ff} != tpar_ff) && (disc_rq < tlow_ff)) begin
                  tlow_in = disc_rq;
                  low_we  = 1'b1; low_wa = tu_ff; low_wd = disc_rq;
               end
               state_in = S_W0;
            end
         end
         S_W3: begin
            tcur_in  = head_rq;
            state_in = S_W0;
         end
         // list done: pop and fold the low link into the parent
         S_P0: begin
            if (depth_ff == TIME_W'(1)) begin
               r_in     = r_ff + TIME_W'(1);
               state_in = S_R0;
            end else begin
               stk_ra   = depth_m2[VTX_W-1:0];
               mu_in    = tu_ff;
               ulow_in  = tlow_ff;
               state_in = S_P1;
            end
         end
         S_P1: begin
            tu_in    = stk_rq.vertex;
            tcur_in  = stk_rq.cursor;
            low_ra   = stk_rq.vertex;
            disc_ra  = stk_rq.vertex;
            par_ra   = stk_rq.vertex;
            depth_in = depth_m1;
            state_in = S_P2;
         end
         S_P2: begin
            tpar_in = par_rq;
            if (ulow_ff < low_rq) begin
               tlow_in = ulow_ff;
               low_we  = 1'b1; low_wa = tu_ff; low_wd = ulow_ff;
            end else begin
               tlow_in = low_rq;
            end
            if (ulow_ff > disc_rq) begin
               head_ra  = tu_ff;
               state_in = S_M0;
            end else begin
               state_in = S_W0;
            end
         end
         // bridge found: mark every stored edge between parent and child
         S_M0: begin
            ms_in    = head_rq;
            state_in = S_M1;
         end
         S_M1: begin
            if (ms_ff == LINK_END) begin
               state_in = S_W0;
            end else begin
               edge_ra  = ms_ff[EIDX_W:1];
               next_ra  = ms_ff[EIDX_W:0];
               state_in = S_M2;
            end
         end
         S_M2: begin
            if (far_ms == mu_ff) begin
               brg_we = 1'b1; brg_wa = ms_ff[EIDX_W:1]; brg_wd = 1'b1;
            end
            ms_in    = next_rq;
            state_in = S_M1;
         end
         // second pass: fresh seen marks
         S_CLR2: begin
            seen_we = 1'b1; seen_wa = idx_ff[VTX_W-1:0]; seen_wd = 1'b0;
            idx_in  = idx_ff + TIME_W'(1);
            if (idx_ff == TIME_W'(MAX_VERTICES - 1)) begin
               r_in     = '0;
               total_in = '0;
               state_in = S_C0;
            end
         end
         S_C0: begin
            if (r_ff == starts) begin
               state_in = S_DONE;
            end else begin
               seen_ra  = r_ff[VTX_W-1:0];
               state_in = S_C1;
            end
         end
         S_C1: begin
            if (seen_rq) begin
               r_in     = r_ff + TIME_W'(1);
               state_in = S_C0;
            end else begin
               seen_we = 1'b1; seen_wa = r_ff[VTX_W-1:0]; seen_wd = 1'b1;
               col_we  = 1'b1; col_wa  = r_ff[VTX_W-1:0]; col_wd  = 1'b0;
               head_ra = r_ff[VTX_W-1:0];
               cnt_in  = OUT_W'(1);
               odd_in  = 1'b0;
               state_in = S_C2;
            end
         end
         S_C2: begin
            tu_in    = r_ff[VTX_W-1:0];
            tcur_in  = head_rq;
            tcol_in  = 1'b0;
            depth_in = TIME_W'(1);
            state_in = S_K0;
         end
         S_K0: begin
            if (tcur_ff == LINK_END) begin
               if (depth_ff == TIME_W'(1)) begin
                  // component finished, saturating add of its size when it holds an odd cycle
                  if (odd_ff) begin
                     total_in = (total_sum > {1'b0, TOTAL_LIMIT}) ? TOTAL_LIMIT
                                                                  : total_sum[OUT_W-1:0];
                  end
                  r_in     = r_ff + TIME_W'(1);
                  state_in = S_C0;
               end else begin
                  stk_ra   = depth_m2[VTX_W-1:0];
                  depth_in = depth_m1;
                  state_in = S_K4;
               end
            end else begin
               edge_ra  = tcur_ff[EIDX_W:1];
               next_ra  = tcur_ff[EIDX_W:0];
               brg_ra   = tcur_ff[EIDX_W:1];
               state_in = S_K1;
            end
         end
         S_K1: begin
            tcur_in = next_rq;
            if (brg_rq) begin
               state_in = S_K0;
            end else begin
               v_in     = far_cur;
               seen_ra  = far_cur;
               col_ra   = far_cur;
               state_in = S_K2;
            end
         end
         S_K2: begin
            if (seen_rq) begin
               if (col_rq == tcol_ff) begin
                  odd_in = 1'b1;
               end
               state_in = S_K0;
            end else begin
               seen_we = 1'b1; seen_wa = v_ff; seen_wd = 1'b1;
               col_we  = 1'b1; col_wa  = v_ff; col_wd  = ~tcol_ff;
               stk_we  = 1'b1; stk_wa  = depth_m1[VTX_W-1:0];
               stk_wd  = '{vertex: tu_ff, cursor: tcur_ff, colour: tcol_ff};
               head_ra = v_ff;
               cnt_in  = cnt_ff + OUT_W'(1);
               tu_in   = v_ff;
               tcol_in = ~tcol_ff;
               depth_in = depth_ff + TIME_W'(1);
               state_in = S_K3;
            end
         end
         S_K3: begin
            tcur_in  = head_rq;
            state_in = S_K0;
         end
         S_K4: begin
            tu_in    = stk_rq.vertex;
            tcur_in  = stk_rq.cursor;
            tcol_in  = stk_rq.colour;
            state_in = S_K0;
         end
         // result word goes out, the graph is emptied for the next case
         S_DONE: begin
            etot_in  = '0;
            ovf_in   = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vcount_ff <= CFG_W'(1);
         etot_ff   <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         etot_ff   <= etot_in;
         ovf_ff    <= ovf_in;
      end
   end

   // walk registers carry no reset, every pass loads them before use
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      e_ff     <= e_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      r_ff     <= r_in;
      tick_ff  <= tick_in;
      depth_ff <= depth_in;
      tu_ff    <= tu_in;
      tcur_ff  <= tcur_in;
      tpar_ff  <= tpar_in;
      tlow_ff  <= tlow_in;
      tcol_ff  <= tcol_in;
      v_ff     <= v_in;
      mu_ff    <= mu_in;
      ulow_ff  <= ulow_in;
      ms_ff    <= ms_in;
      cnt_ff   <= cnt_in;
      odd_ff   <= odd_in;
      total_ff <= total_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = (state_ff == S_DONE);
   assign rsp_odd_vertex_total = total_ff;
   assign rsp_edges_dropped    = ovf_ff;
   assign csr_ready            = 1'b1;

   // edge store, both endpoints in one word
   bpoc_ram #(.WIDTH(2*VTX_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .we(edge_we), .wa(edge_wa), .wd(edge_wd), .ra(edge_ra), .rq(edge_rq));
   bpoc_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_VERTICES)) u_head (
      .clock(clock), .we(head_we), .wa(head_wa), .wd(head_wd), .ra(head_ra), .rq(head_rq));
   bpoc_ram #(.WIDTH(SLOT_W), .DEPTH(2*MAX_EDGES)) u_next (
      .clock(clock), .we(next_we), .wa(next_wa), .wd(next_wd), .ra(next_ra), .rq(next_rq));
   bpoc_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_bridge (
      .clock(clock), .we(brg_we), .wa(brg_wa), .wd(brg_wd), .ra(brg_ra), .rq(brg_rq));
   bpoc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_seen (
      .clock(clock), .we(seen_we), .wa(seen_wa), .wd(seen_wd), .ra(seen_ra), .rq(seen_rq));
   bpoc_ram #(.WIDTH(VTX_W+1), .DEPTH(MAX_VERTICES)) u_parent (
      .clock(clock), .we(par_we), .wa(par_wa), .wd(par_wd), .ra(par_ra), .rq(par_rq));
   bpoc_ram #(.WIDTH(TIME_W), .DEPTH(MAX_VERTICES)) u_disc (
      .clock(clock), .we(disc_we), .wa(disc_wa), .wd(disc_wd), .ra(disc_ra), .rq(disc_rq));
   bpoc_ram #(.WIDTH(TIME_W), .DEPTH(MAX_VERTICES)) u_low (
      .clock(clock), .we(low_we), .wa(low_wa), .wd(low_wd), .ra(low_ra), .rq(low_rq));
   bpoc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_colour (
      .clock(clock), .we(col_we), .wa(col_wa), .wd(col_wd), .ra(col_ra), .rq(col_rq));
   bpoc_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .we(stk_we), .wa(stk_wa), .wd(stk_wd), .ra(stk_ra), .rq(stk_rq));

endmodule

// ===== hw/rtl/bpoc_checker.sv =====
// bpoc_checker: port level checks on the odd cycle vertex counter, bound to the top level
// depends on bpoc_pkg
module bpoc_checker
   import bpoc_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_kind,
   input logic rsp_valid
);

   // one strobe per finish word
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // after the result the block is free again
   a_free_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");

   // an edge word is stored while busy stays low
   a_edge_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_EDGE)) |=> (!busy && !rsp_valid))
      else $error("edge word stalled the block");

   // a finish word always leads into the compute phase
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_FINISH)) |=> busy)
      else $error("finish word not taken");

   // reset leaves the block idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid)) else $error("not idle after reset");

endmodule

bind bridge_pruned_odd_cycle_vertex_count bpoc_checker u_bpoc_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_kind(req_kind),
   .rsp_valid(rsp_valid)
);
